// ===== rtl/assert_macros.svh =====
// Assertion helpers for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stn_pkg.sv =====
// ---------------------------------------------------------------------------
// stn_pkg
// Shared types, widths and CORDIC constants of the Stanley steering core.
// ---------------------------------------------------------------------------
`default_nettype none

package stn_pkg;

   // Widths of the rotation CORDIC (Q.28 sin/cos, Q.24 angle).
   localparam int ROT_W   = 31;
   localparam int ROT_Z_W = 28;
   // Widths of the vectoring CORDIC (normalized operands, Q.24 angle).
   localparam int VEC_W   = 56;
   localparam int VEC_Z_W = 28;

   localparam int ATAN_LEN = 24;
   localparam int ATAN_W   = 24;

   // atan(2^-i) in Q.24 radians.
   localparam logic [ATAN_W-1:0] ATAN_TBL [ATAN_LEN] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214,  24'd524117,  24'd262123,  24'd131069,
      24'd65536,    24'd32768,   24'd16384,   24'd8192,
      24'd4096,     24'd2048,    24'd1024,    24'd512,
      24'd256,      24'd128,     24'd64,      24'd32,
      24'd16,       24'd8,       24'd4,       24'd2
   };

   // Inverse CORDIC gain in Q.28, the start value of the rotation.
   localparam logic signed [ROT_W-1:0] INV_GAIN_Q28 = 31'sd163008219;

   // Pipeline advance and the valid bit entering a unit.
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/stn_cordic_rot.sv =====
// ---------------------------------------------------------------------------
// stn_cordic_rot
// Pipelined rotation CORDIC, one iteration per stage, giving cos and sin.
// ---------------------------------------------------------------------------
`default_nettype none

module stn_cordic_rot import stn_pkg::*; #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pipe_ctl_type               ctl,
   input  wire logic signed [ROT_Z_W-1:0]  z_start,
   input  wire logic        [SIDE_W-1:0]   side_start,
   output logic                            valid_out,
   output logic signed [ROT_W-1:0]         cos_out,
   output logic signed [ROT_W-1:0]         sin_out,
   output logic        [SIDE_W-1:0]        side_out
);

   localparam int N = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

   logic signed [ROT_W-1:0]   x_s    [N+1];
   logic signed [ROT_W-1:0]   y_s    [N+1];
   logic signed [ROT_Z_W-1:0] z_s    [N+1];
   logic        [SIDE_W-1:0]  side_s [N+1];
   logic                      v_s    [N+1];

   assign x_s[0]    = INV_GAIN_Q28;
   assign y_s[0]    = '0;
   assign z_s[0]    = z_start;
   assign side_s[0] = side_start;
   assign v_s[0]    = ctl.valid;

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [ROT_Z_W-1:0] ANG =
         $signed({{(ROT_Z_W-ATAN_W){1'b0}}, ATAN_TBL[i]});
      logic signed [ROT_W-1:0]   x_in, y_in, x_ff, y_ff;
      logic signed [ROT_Z_W-1:0] z_in, z_ff;
      logic        [SIDE_W-1:0]  side_ff;
      logic                      v_ff;

      always_comb begin
         if (!z_s[i][ROT_Z_W-1]) begin
            x_in = x_s[i] - (y_s[i] >>> i);
            y_in = y_s[i] + (x_s[i] >>> i);
            z_in = z_s[i] - ANG;
         end else begin
            x_in = x_s[i] + (y_s[i] >>> i);
            y_in = y_s[i] - (x_s[i] >>> i);
            z_in = z_s[i] + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            side_ff <= side_s[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (ctl.en) begin
            v_ff <= v_s[i];
         end
      end

      assign x_s[i+1]    = x_ff;
      assign y_s[i+1]    = y_ff;
      assign z_s[i+1]    = z_ff;
      assign side_s[i+1] = side_ff;
      assign v_s[i+1]    = v_ff;
   end

   assign valid_out = v_s[N];
   assign cos_out   = x_s[N];
   assign sin_out   = y_s[N];
   assign side_out  = side_s[N];

endmodule

`default_nettype wire

// ===== rtl/stn_cordic_vec.sv =====
// ---------------------------------------------------------------------------
// stn_cordic_vec
// Pipelined vectoring CORDIC, one iteration per stage, giving atan2(y, x).
// ---------------------------------------------------------------------------
`default_nettype none

module stn_cordic_vec import stn_pkg::*; #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pipe_ctl_type               ctl,
   input  wire logic signed [VEC_W-1:0]    x_start,
   input  wire logic signed [VEC_W-1:0]    y_start,
   input  wire logic        [SIDE_W-1:0]   side_start,
   output logic                            valid_out,
   output logic signed [VEC_Z_W-1:0]       angle_out,
   output logic        [SIDE_W-1:0]        side_out
);

   localparam int N = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

   logic signed [VEC_W-1:0]   x_s    [N+1];
   logic signed [VEC_W-1:0]   y_s    [N+1];
   logic signed [VEC_Z_W-1:0] z_s    [N+1];
   logic        [SIDE_W-1:0]  side_s [N+1];
   logic                      v_s    [N+1];

   assign x_s[0]    = x_start;
   assign y_s[0]    = y_start;
   assign z_s[0]    = '0;
   assign side_s[0] = side_start;
   assign v_s[0]    = ctl.valid;

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [VEC_Z_W-1:0] ANG =
         $signed({{(VEC_Z_W-ATAN_W){1'b0}}, ATAN_TBL[i]});
      logic signed [VEC_W-1:0]   x_in, y_in, x_ff, y_ff;
      logic signed [VEC_Z_W-1:0] z_in, z_ff;
      logic        [SIDE_W-1:0]  side_ff;
      logic                      v_ff;

      always_comb begin
         if (!y_s[i][VEC_W-1]) begin
            x_in = x_s[i] + (y_s[i] >>> i);
            y_in = y_s[i] - (x_s[i] >>> i);
            z_in = z_s[i] + ANG;
         end else begin
            x_in = x_s[i] - (y_s[i] >>> i);
            y_in = y_s[i] + (x_s[i] >>> i);
            z_in = z_s[i] - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            side_ff <= side_s[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (ctl.en) begin
            v_ff <= v_s[i];
         end
      end

      assign x_s[i+1]    = x_ff;
      assign y_s[i+1]    = y_ff;
      assign z_s[i+1]    = z_ff;
      assign side_s[i+1] = side_ff;
      assign v_s[i+1]    = v_ff;
   end

   assign valid_out = v_s[N];
   assign angle_out = z_s[N];
   assign side_out  = side_s[N];

endmodule

`default_nettype wire

// ===== rtl/stanley_steering_law_core.sv =====
// Path: an accepted req transfer passes stage A, the rotation CORDIC, stages B
// to F, the vectoring CORDIC, stage G and the output register before rsp_tvalid.
// Throughput: one item per cycle while the skid entry is empty; a two-entry
// output (register plus skid) keeps accepting while a result waits.
// Reset: synchronous, active high; clears all valid bits and loads the
// gain (0.8) and steering limit (1.0) registers.
// ---------------------------------------------------------------------------
// stanley_steering_law_core
// Stanley lateral steering law: cross-track and heading error, atan2 term
// and clamping, in a fully pipelined fixed-point datapath.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stanley_steering_law_core import stn_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input channel. tdata, lowest bit up: ref_x[31:0], ref_y[31:0],
   // ref_heading[15:0], veh_x[31:0], veh_y[31:0], veh_heading[15:0],
   // veh_speed[15:0].
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [175:0] req_tdata,
   // Result channel. tdata: steer_angle[15:0]. tuser: clamped.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic [0:0]        rsp_tuser,
   // Configuration writes: index 0 cross_track_gain, index 1 steer_limit.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   localparam logic [7:0] REG_GAIN  = 8'd0;
   localparam logic [7:0] REG_LIMIT = 8'd1;

   localparam logic signed [ROT_Z_W-1:0] PI_Q24      = 28'sd52707179;
   localparam logic signed [ROT_Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [17:0]        PI_Q13      = 18'sd25736;
   localparam logic signed [17:0]        TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [VEC_Z_W-1:0] ROUND_HALF  = 28'sd1024;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [17:0] herr;
      logic        [15:0] spd;
      logic               flip;
   } rot_side_type;

   typedef struct packed {
      logic signed [17:0] herr;
      logic               zero;
   } vec_side_type;

   // Leading zeros of a 16-bit chunk, 16 when it is all zero.
   function automatic logic [4:0] lz16(input logic [15:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd16;
      hit = 1'b0;
      for (int b = 15; b >= 0; b--) begin
         if (v[b] && !hit) begin
            n   = 5'(15 - b);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // ---------------- Configuration registers ----------------
   // The port never stalls; unknown indexes are dropped.
   logic [15:0] gain_ff;
   logic [14:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 16'd3277;
         limit_ff <= 15'd8192;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAIN:  gain_ff  <= csr_data;
            REG_LIMIT: limit_ff <= csr_data[14:0];
            default:   ;
         endcase
      end
   end

   // ---------------- Pipeline control ----------------
   // Every stage moves together; the whole pipe only freezes while the skid
   // entry holds a result, so no transfer is lost or repeated.
   logic         skid_v_ff;
   logic         en;
   pipe_ctl_type rot_ctl, vec_ctl;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   // ---------------- Stage A: differences, heading error, fold ----------------
   logic signed [31:0] in_rx, in_ry, in_vx, in_vy;
   logic signed [15:0] in_rh, in_vh;
   logic signed [16:0] hdiff;
   logic signed [17:0] herr_w;
   logic signed [ROT_Z_W-1:0] zr;
   rot_side_type a_side_in, a_side_ff;
   logic signed [ROT_Z_W-1:0] a_z_in, a_z_ff;
   logic a_v_ff;

   assign in_rx = $signed(req_tdata[31:0]);
   assign in_ry = $signed(req_tdata[63:32]);
   assign in_rh = $signed(req_tdata[79:64]);
   assign in_vx = $signed(req_tdata[111:80]);
   assign in_vy = $signed(req_tdata[143:112]);
   assign in_vh = $signed(req_tdata[159:144]);

   always_comb begin
      hdiff  = {in_rh[15], in_rh} - {in_vh[15], in_vh};
      herr_w = {hdiff[16], hdiff};
      // Wrap once from each side, the second test sees the first result.
      if (herr_w > PI_Q13) begin
         herr_w = herr_w - TWO_PI_Q13;
      end
      if (herr_w < -PI_Q13) begin
         herr_w = herr_w + TWO_PI_Q13;
      end

      zr             = {in_rh[15], in_rh, 11'b0};
      a_side_in.flip = 1'b0;
      a_z_in         = zr;
      // Fold the angle into the CORDIC range; cos and sin change sign later.
      if (zr > HALF_PI_Q24) begin
         a_z_in         = zr - PI_Q24;
         a_side_in.flip = 1'b1;
      end else if (zr < -HALF_PI_Q24) begin
         a_z_in         = zr + PI_Q24;
         a_side_in.flip = 1'b1;
      end

      a_side_in.dx   = {in_rx[31], in_rx} - {in_vx[31], in_vx};
      a_side_in.dy   = {in_ry[31], in_ry} - {in_vy[31], in_vy};
      a_side_in.herr = herr_w;
      a_side_in.spd  = req_tdata[175:160];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         a_z_ff    <= a_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
      end
   end

   // ---------------- Rotation CORDIC: cos and sin of the path heading -------
   logic                      rot_v;
   logic signed [ROT_W-1:0]   rot_cos, rot_sin;
   logic [$bits(rot_side_type)-1:0] rot_side_bits;
   rot_side_type              rot_side;

   assign rot_ctl.en    = en;
   assign rot_ctl.valid = a_v_ff;

   stn_cordic_rot #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(rot_side_type))
   ) u_rot (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rot_ctl),
      .z_start    (a_z_ff),
      .side_start (a_side_ff),
      .valid_out  (rot_v),
      .cos_out    (rot_cos),
      .sin_out    (rot_sin),
      .side_out   (rot_side_bits)
   );

   assign rot_side = rot_side_type'(rot_side_bits);

   // ---------------- Stage B: products for the cross-track error ------------
   logic signed [ROT_W-1:0] cval, sval;
   logic signed [63:0]      b_pc_in, b_ps_in, b_pc_ff, b_ps_ff;
   logic signed [17:0]      b_herr_ff;
   logic [15:0]             b_spd_ff;
   logic                    b_v_ff;

   assign cval    = rot_side.flip ? -rot_cos : rot_cos;
   assign sval    = rot_side.flip ? -rot_sin : rot_sin;
   assign b_pc_in = rot_side.dy * cval;
   assign b_ps_in = rot_side.dx * sval;

   always_ff @(posedge clock) begin
      if (en) begin
         b_pc_ff   <= b_pc_in;
         b_ps_ff   <= b_ps_in;
         b_herr_ff <= rot_side.herr;
         b_spd_ff  <= rot_side.spd;
      end
   end

   // ---------------- Stage C: cross-track error in Q.16 ----------------
   logic signed [64:0] c_diff;
   logic signed [36:0] c_ey_ff;
   logic signed [17:0] c_herr_ff;
   logic [15:0]        c_spd_ff;
   logic               c_v_ff;

   assign c_diff = {b_pc_ff[63], b_pc_ff} - {b_ps_ff[63], b_ps_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         c_ey_ff   <= c_diff[64:28];
         c_herr_ff <= b_herr_ff;
         c_spd_ff  <= b_spd_ff;
      end
   end

   // ---------------- Stage D: atan2 operands ----------------
   logic signed [53:0] d_num_in, d_num_ff;
   logic [35:0]        d_den_ff;
   logic signed [17:0] d_herr_ff;
   logic               d_v_ff;

   assign d_num_in = $signed({1'b0, gain_ff}) * c_ey_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_num_ff  <= d_num_in;
         d_den_ff  <= {c_spd_ff, 20'b0};
         d_herr_ff <= c_herr_ff;
      end
   end

   // ---------------- Stage E: leading-zero search, first half --------------
   // The larger operand has the same top bit as the OR of both magnitudes.
   logic [53:0]        e_mag;
   logic signed [53:0] e_num_ff;
   logic [35:0]        e_den_ff;
   logic signed [17:0] e_herr_ff;
   logic [4:0]         e_lz2_ff, e_lz1_ff, e_lz0_ff;
   logic               e_big_ff, e_zero_ff, e_v_ff;

   always_comb begin
      e_mag = d_num_ff[53] ? 54'(-d_num_ff) : 54'(d_num_ff);
      e_mag = e_mag | {18'b0, d_den_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_num_ff  <= d_num_ff;
         e_den_ff  <= d_den_ff;
         e_herr_ff <= d_herr_ff;
         e_big_ff  <= |e_mag[53:47];
         e_lz2_ff  <= lz16(e_mag[47:32]);
         e_lz1_ff  <= lz16(e_mag[31:16]);
         e_lz0_ff  <= lz16(e_mag[15:0]);
         e_zero_ff <= (d_num_ff == '0);
      end
   end

   // ---------------- Stage F: shift count and normalization ----------------
   logic [5:0]              f_k;
   logic signed [VEC_W-1:0] f_x_in, f_y_in, f_x_ff, f_y_ff;
   vec_side_type            f_side_ff;
   logic                    f_v_ff;

   always_comb begin
      if (e_big_ff) begin
         f_k = 6'd0;
      end else if (e_lz2_ff != 5'd16) begin
         f_k = {1'b0, e_lz2_ff};
      end else if (e_lz1_ff != 5'd16) begin
         f_k = 6'd16 + {1'b0, e_lz1_ff};
      end else begin
         f_k = 6'd32 + {1'b0, e_lz0_ff};
      end
      f_y_in = {{(VEC_W-54){e_num_ff[53]}}, e_num_ff} <<< f_k;
      f_x_in = $signed({{(VEC_W-36){1'b0}}, e_den_ff}) <<< f_k;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_x_ff         <= f_x_in;
         f_y_ff         <= f_y_in;
         f_side_ff.herr <= e_herr_ff;
         f_side_ff.zero <= e_zero_ff;
      end
   end

   // Valid bits of stages B to F.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= rot_v;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
      end
   end

   // ---------------- Vectoring CORDIC: atan2 term ----------------
   logic                      vec_v;
   logic signed [VEC_Z_W-1:0] vec_z;
   logic [$bits(vec_side_type)-1:0] vec_side_bits;
   vec_side_type              vec_side;

   assign vec_ctl.en    = en;
   assign vec_ctl.valid = f_v_ff;

   stn_cordic_vec #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(vec_side_type))
   ) u_vec (
      .clock      (clock),
      .reset      (reset),
      .ctl        (vec_ctl),
      .x_start    (f_x_ff),
      .y_start    (f_y_ff),
      .side_start (f_side_ff),
      .valid_out  (vec_v),
      .angle_out  (vec_z),
      .side_out   (vec_side_bits)
   );

   assign vec_side = vec_side_type'(vec_side_bits);

   // ---------------- Stage G: sum, rounding and clamp ----------------
   logic signed [VEC_Z_W-1:0] g_round;
   logic signed [16:0]        g_atan;
   logic signed [18:0]        g_raw, g_lim;
   logic [15:0]               g_steer_in, g_steer_ff;
   logic                      g_clamp_in, g_clamp_ff, g_v_ff;

   always_comb begin
      g_round = vec_z + ROUND_HALF;
      // A zero numerator gives a zero atan2 term, whatever the speed.
      g_atan  = vec_side.zero ? 17'sd0 : g_round[VEC_Z_W-1:11];
      g_raw   = {vec_side.herr[17], vec_side.herr} + {{2{g_atan[16]}}, g_atan};
      g_lim   = $signed({4'b0, limit_ff});
      g_steer_in = g_raw[15:0];
      g_clamp_in = 1'b0;
      if (g_raw > g_lim) begin
         g_steer_in = g_lim[15:0];
         g_clamp_in = 1'b1;
      end else if (g_raw < -g_lim) begin
         g_steer_in = 16'(-g_lim);
         g_clamp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_steer_ff <= g_steer_in;
         g_clamp_ff <= g_clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en) begin
         g_v_ff <= vec_v;
      end
   end

   // ---------------- Output register and skid entry ----------------
   // When the output is held and a new result arrives, it parks in the skid
   // entry; the pipe then freezes until the output has been freed.
   logic        rsp_v_ff, rsp_free;
   logic [15:0] rsp_d_ff, skid_d_ff;
   logic        rsp_c_ff, skid_c_ff;

   assign rsp_free = !rsp_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff  <= g_v_ff;
         end
      end else if (g_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_v_ff) begin
            rsp_d_ff <= skid_d_ff;
            rsp_c_ff <= skid_c_ff;
         end else begin
            rsp_d_ff <= g_steer_ff;
            rsp_c_ff <= g_clamp_ff;
         end
      end else if (en) begin
         skid_d_ff <= g_steer_ff;
         skid_c_ff <= g_clamp_ff;
      end
   end

   assign rsp_tvalid   = rsp_v_ff;
   assign rsp_tdata    = rsp_d_ff;
   assign rsp_tuser[0] = rsp_c_ff;

   // ---------------- Assertions ----------------
   // The skid entry is only ever occupied behind a held output.
   `ASSERT_SAME(a_skid_behind_out, clock, reset, skid_v_ff, rsp_v_ff, "skid full with output empty")
   // A result arriving at a held output must be parked, not dropped.
   `ASSERT_NEXT(a_skid_catches, clock, reset, rsp_v_ff && !rsp_tready && g_v_ff && en, skid_v_ff, "result lost at held output")

endmodule

`default_nettype wire

// ===== tb/sv/stanley_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stanley_checker
// Watches the pose and steering channels of the Stanley core, predicts the
// steering command of every accepted pose and compares each result with it.
// ---------------------------------------------------------------------------

module stanley_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [175:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [15:0]  rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   output int                fail_count,
   output int                steer_pending
);
   localparam int CSR_GAIN  = 0;
   localparam int CSR_LIMIT = 1;
   localparam int N_STAGES  = 16;
   localparam longint PI_24 = 52707179;
   localparam longint HALF_PI_24 = 26353589;
   localparam longint NORM_LIM = 64'sd1 <<< 47;

   typedef struct packed {
      logic [15:0] angle;
      logic        sat;
   } steer_cmd_type;

   longint atan_lut [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   steer_cmd_type steer_q[$];
   logic [15:0]   gain_reg;
   logic [14:0]   limit_reg;

   // Rotation CORDIC: heading in Q.24 to cos and sin in Q.28.
   function automatic void heading_sincos(input longint a, output longint c,
                                          output longint s);
      longint x, y, z, nx;
      bit flip;
      x = 163008219; y = 0; z = a; flip = 0;
      if (z > HALF_PI_24) begin
         z -= PI_24; flip = 1;
      end else if (z < -HALF_PI_24) begin
         z += PI_24; flip = 1;
      end
      for (int i = 0; i < N_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Vectoring CORDIC for a nonnegative denominator, angle in Q.24.
   function automatic longint track_atan2(longint y, longint x);
      longint z, nx;
      z = 0;
      if (y == 0) return 0;
      while (x < NORM_LIM && y < NORM_LIM && y > -NORM_LIM) begin
         x = x * 2; y = y * 2;
      end
      for (int i = 0; i < N_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
         end else begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic steer_cmd_type steer_law(logic [175:0] d);
      longint rx, ry, rh, vx, vy, vh, spd, dx, dy, c, s, ey, herr, st, lim;
      steer_cmd_type r;
      rx = longint'($signed(d[31:0]));
      ry = longint'($signed(d[63:32]));
      rh = longint'($signed(d[79:64]));
      vx = longint'($signed(d[111:80]));
      vy = longint'($signed(d[143:112]));
      vh = longint'($signed(d[159:144]));
      spd = longint'(d[175:160]);
      dx = rx - vx; dy = ry - vy;
      heading_sincos(rh * 2048, c, s);
      ey = (dy * c - dx * s) >>> 28;
      herr = rh - vh;
      if (herr > 25736) herr -= 51472;
      if (herr < -25736) herr += 51472;
      st = herr + ((track_atan2(longint'(gain_reg) * ey, spd * 1048576) + 1024) >>> 11);
      lim = longint'(limit_reg);
      r.sat = 0;
      if (st > lim) begin
         st = lim; r.sat = 1;
      end else if (st < -lim) begin
         st = -lim; r.sat = 1;
      end
      r.angle = st[15:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      steer_cmd_type e;
      if (reset) begin
         gain_reg  <= 16'd3277;
         limit_reg <= 15'd8192;
         fail_count <= 0;
         steer_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (steer_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 16'h0);
            end else begin
               e = steer_q.pop_front();
               if (rsp_tdata !== e.angle) report_mismatch("steer_angle", rsp_tdata, e.angle);
               if (rsp_tuser[0] !== e.sat)
                  report_mismatch("clamped", {15'b0, rsp_tuser}, {15'b0, e.sat});
            end
         end
         // Poses accepted here are computed with the registers in force before the write.
         if (req_tvalid && req_tready) steer_q.push_back(steer_law(req_tdata));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GAIN) gain_reg <= csr_data;
            else if (csr_index == CSR_LIMIT) limit_reg <= csr_data[14:0];
         end
      end
      steer_pending <= steer_q.size();
   end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Stanley steering core: directed poses, then
// random poses under several gain and limit settings with random stalls.
// ---------------------------------------------------------------------------

module tb;
   localparam logic [7:0] CSR_GAIN  = 8'd0;
   localparam logic [7:0] CSR_LIMIT = 8'd1;
   localparam logic [7:0] CSR_BOGUS = 8'd7;
   // Pipeline depth plus the output skid, with margin.
   localparam int DRAIN_CYCLES = 60;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [15:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;
   int           fail_count;
   int           steer_pending;

   // Random stalls are turned off for the last stretch of the run.
   bit           calm = 0;
   // Set while the result side is holding off on purpose.
   bit           hold_rsp = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   stanley_steering_law_core u_top (.*);

   stanley_checker u_chk (.*);

   // Result side: random bursts of backpressure, plus one long hold.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_tready <= 1;
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'h7fffffff - $urandom_range(0, 3);
         2: return 32'h80000000 + $urandom_range(0, 3);
         default: return $urandom_range(0, 32'h00400000) - 32'h00200000;
      endcase
   endfunction

   function automatic logic [15:0] rand_heading();
      if ($urandom_range(0, 9) == 0) return 16'($urandom());
      return 16'($urandom_range(0, 51472)) - 16'd25736;
   endfunction

   function automatic logic [15:0] rand_speed();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hffff;
         default: return 16'($urandom());
      endcase
   endfunction

   // One transfer on the pose channel; valid stays high across back-to-back items.
   task automatic send_pose(input logic [31:0] rx, ry, input logic [15:0] rh,
                            input logic [31:0] vx, vy, input logic [15:0] vh, sp);
      req_tvalid <= 1;
      req_tdata  <= {sp, vh, vy, vx, rh, ry, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_gap();
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      req_tvalid <= 0;
      // A clock edge first, so that the count includes the last accepted pose.
      @(posedge clock);
      while (steer_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_poses(input int count);
      for (int k = 0; k < count; k++) begin
         send_pose(rand_pos(), rand_pos(), rand_heading(), rand_pos(), rand_pos(),
                   rand_heading(), rand_speed());
         idle_gap();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, zero numerator, zero speed, unwrapped headings.
      send_pose(0, 0, 0, 0, 0, 0, 0);
      send_pose(0, 32'h00010000, 0, 0, 0, 0, 0);
      send_pose(0, 32'hffff0000, 0, 0, 0, 0, 0);
      send_pose(32'h7fffffff, 32'h7fffffff, 16'd25736, 32'h80000000, 32'h80000000,
                -16'sd25736, 16'hffff);
      send_pose(32'h80000000, 32'h80000000, -16'sd25736, 32'h7fffffff, 32'h7fffffff,
                16'd25736, 16'd1);
      send_pose(0, 0, 16'h7fff, 0, 0, 16'h8000, 16'd256);
      send_pose(0, 0, 16'h8000, 0, 0, 16'h7fff, 16'd256);
      send_pose(32'h00020000, 32'h00030000, 16'd12868, 0, 0, -16'sd12868, 16'd512);
      send_pose(32'hfffe0000, 32'h00010000, -16'sd20000, 0, 0, 16'd20000, 16'hffff);
      send_pose(32'h00001000, 0, 16'd13000, 32'h00002000, 0, 16'd0, 16'd0);
      send_pose(32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff, 32'hffffffff,
                16'hffff, 16'hffff);
      random_poses(150);

      // Extremes of both registers, plus an index the core must ignore.
      write_reg(CSR_GAIN, 16'hffff);
      write_reg(CSR_LIMIT, 16'h7fff);
      write_reg(CSR_BOGUS, 16'h0001);
      random_poses(150);
      write_reg(CSR_GAIN, 16'h0000);
      write_reg(CSR_LIMIT, 16'h0000);
      random_poses(100);
      write_reg(CSR_GAIN, 16'($urandom()));
      write_reg(CSR_LIMIT, 16'd25736);
      random_poses(150);

      // Long hold on the result side while poses keep coming, to fill the pipe.
      hold_rsp = 1;
      fork
         random_poses(100);
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
      join

      write_reg(CSR_GAIN, 16'd3277);
      write_reg(CSR_LIMIT, 16'd8192);
      random_poses(150);

      calm = 1;
      random_poses(150);
      req_tvalid <= 0;

      @(posedge clock);
      while (steer_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
